// ===== rtl/kmwr_pkg.sv =====
// ----------------------------------------------------------------------------
// kmwr_pkg
// Shared types and codes for the Kruskal maze wall remover: sequencer
// states, result status codes, input modes and register indexes.
// ----------------------------------------------------------------------------
package kmwr_pkg;

  localparam int DEF_MAX_CELLS = 1024;
  localparam int CFG_W         = 11;
  localparam int WALL_W        = 11;
  localparam int STATUS_W      = 3;

  localparam logic [CFG_W-1:0] COLUMNS_RESET = 11'd32;
  localparam logic [CFG_W-1:0] ROWS_RESET    = 11'd32;

  // configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // request modes
  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_PROPOSE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_REMOVED   = 3'd0,
    STATUS_BORDER    = 3'd1,
    STATUS_CONNECTED = 3'd2,
    STATUS_COMPLETE  = 3'd3,
    STATUS_RANGE     = 3'd4,
    STATUS_RESTARTED = 3'd5
  } kmwr_status_t;

  typedef enum logic [3:0] {
    ST_START,
    ST_LIMIT,
    ST_CELLS,
    ST_CLEAR,
    ST_IDLE,
    ST_PROP,
    ST_DIV,
    ST_CHECK,
    ST_FIND_A,
    ST_FIND_B,
    ST_LINK,
    ST_OUT
  } kmwr_state_t;

endpackage

// ===== rtl/kmwr_div.sv =====
// ----------------------------------------------------------------------------
// kmwr_div
// Restoring divider, one quotient bit per cycle. Gives quotient and
// remainder together with done, which pulses for one cycle.
// ----------------------------------------------------------------------------
module kmwr_div #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             ge;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(W);
        quo <= dividend;
        rem <= '0;
      end else if (cnt != '0) begin
        rem <= ge ? diff[W-1:0] : shifted[W-1:0];
        quo <= {quo[W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/kruskal_maze_wall_remover.sv =====
// ----------------------------------------------------------------------------
// kruskal_maze_wall_remover
// Union-find core of a randomised Kruskal maze builder.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_tuser selects restart (0) or wall
// proposal (1), s_tdata carries the wall index (even: east wall, odd: south
// wall of cell index/2). Every request gives exactly one result on the m_
// channel: status, echoed wall, sets remaining and a done flag.
// Grid size is set through cfg_we/cfg_index/cfg_data (0 columns, 1 rows);
// a write restarts the maze.
// One request is worked on at a time; s_tready is high only when idle.
// A proposal that reaches the root searches runs the shared divider (width
// W = clog2(MAX_CELLS)+1) to find the column, then walks the parent links of
// both cells in two root searches and links the roots if they differ. A
// border wall stops after the divider; a finished maze or an out-of-range
// cell goes straight to the result.
// A restart runs the divider for the row limit, one multiply for the cell
// count, then a clearing pass over all MAX_CELLS entries of the parent memory
// before its result. A configuration write or reset runs the same sequence
// but gives no result of its own.
// The result sits in an output register; while the receiver stalls the
// block holds it and does not start the next request's result.
// ----------------------------------------------------------------------------
module kruskal_maze_wall_remover
  import kmwr_pkg::*;
#(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [10:0] wall_index
  input  logic [0:0]  s_tuser,    // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [2:0] status, [13:3] wall_echo,
                                  // [24:14] sets_left, [25] maze_done
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CW = $clog2(MAX_CELLS);
  localparam int NW = CW + 1;
  localparam int EW = (NW > CFG_W) ? NW : CFG_W;
  localparam logic [CW-1:0] LAST_CELL = CW'(MAX_CELLS - 1);

  kmwr_state_t state, state_next;

  logic [CFG_W-1:0]  grid_columns;
  logic [CFG_W-1:0]  grid_rows;
  logic              restart_pend;
  logic [WALL_W-1:0] wall;
  logic [NW-1:0]     cells;
  logic [NW-1:0]     set_count;
  logic [CW-1:0]     clr_idx;
  logic [CW-1:0]     cur;
  logic [CW-1:0]     ra;
  logic [CW-1:0]     rb;
  kmwr_status_t      res_status;

  // parent memory
  logic [CW-1:0] parent_mem [MAX_CELLS];
  logic [CW-1:0] rdata;
  logic [CW-1:0] rd_addr;
  logic          mem_we;
  logic [CW-1:0] wr_addr;
  logic [CW-1:0] wr_data;

  // divider
  logic          div_start;
  logic [NW-1:0] div_dvd;
  logic          div_done;
  logic [NW-1:0] div_quot;
  logic [NW-1:0] div_rem;

  // geometry
  logic [EW-1:0]   col_w;
  logic [EW-1:0]   row_w;
  logic [NW-1:0]   cols_eff;
  logic [NW-1:0]   rows_eff;
  logic [2*NW-1:0] prod;

  // proposal datapath
  logic [WALL_W-2:0] a_raw;
  logic [CW-1:0]     cell_a;
  logic [NW-1:0]     b_sum;
  logic [CW-1:0]     b_cell;
  logic [NW:0]       a_plus;
  logic              out_range;
  logic              border;
  logic              out_free;
  logic [31:0]       sc_wide;

  kmwr_div #(
    .W (NW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (cols_eff),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // effective columns and rows: zero taken as one, grid held within capacity
  always_comb begin
    col_w = EW'(grid_columns);
    if (col_w == '0) begin
      col_w = EW'(1);
    end
    if (col_w > EW'(MAX_CELLS)) begin
      col_w = EW'(MAX_CELLS);
    end
    cols_eff = NW'(col_w);

    row_w = EW'(grid_rows);
    if (row_w == '0) begin
      row_w = EW'(1);
    end
    if (row_w > EW'(div_quot)) begin
      row_w = EW'(div_quot);
    end
    rows_eff = NW'(row_w);
  end

  assign prod = cols_eff * rows_eff;

  assign a_raw     = wall[WALL_W-1:1];
  assign cell_a    = CW'(a_raw);
  assign out_range = EW'(a_raw) >= EW'(cells);
  assign b_sum     = wall[0] ? (NW'(cell_a) + cols_eff) : (NW'(cell_a) + NW'(1));
  assign b_cell    = CW'(b_sum);
  assign a_plus    = (NW+1)'(cell_a) + (NW+1)'(cols_eff);
  assign border    = wall[0] ? (a_plus >= (NW+1)'(cells))
                             : (div_rem == (cols_eff - NW'(1)));
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign sc_wide   = 32'(set_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvd    = NW'(MAX_CELLS);
    mem_we     = 1'b0;
    wr_addr    = clr_idx;
    wr_data    = clr_idx;
    rd_addr    = cur;
    case (state)
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_LIMIT;
      end
      ST_LIMIT: begin
        if (div_done) begin
          state_next = ST_CELLS;
        end
      end
      ST_CELLS: begin
        state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx == LAST_CELL) begin
          state_next = restart_pend ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser[0] == MODE_RESTART) ? ST_START : ST_PROP;
        end
      end
      ST_PROP: begin
        if (set_count <= NW'(1) || out_range) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          div_dvd    = NW'(cell_a);
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (border) begin
          state_next = ST_OUT;
        end else begin
          rd_addr    = cell_a;
          state_next = ST_FIND_A;
        end
      end
      ST_FIND_A: begin
        if (rdata == cur) begin
          rd_addr    = b_cell;
          state_next = ST_FIND_B;
        end else begin
          rd_addr = rdata;
        end
      end
      ST_FIND_B: begin
        if (rdata == cur) begin
          state_next = ST_LINK;
        end else begin
          rd_addr = rdata;
        end
      end
      ST_LINK: begin
        if (ra != rb) begin
          mem_we  = 1'b1;
          wr_addr = ra;
          wr_data = rb;
        end
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_START;
      end
    endcase
    // a register write restarts the maze from any point
    if (cfg_we) begin
      state_next = ST_START;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      parent_mem[wr_addr] <= wr_data;
    end
    rdata <= parent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= COLUMNS_RESET;
      grid_rows    <= ROWS_RESET;
      restart_pend <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_COLUMNS) begin
          grid_columns <= cfg_data;
        end else begin
          grid_rows <= cfg_data;
        end
      end
      if (state == ST_IDLE && s_tvalid && s_tuser[0] == MODE_RESTART) begin
        restart_pend <= 1'b1;
      end
      if (state == ST_CLEAR && clr_idx == LAST_CELL) begin
        restart_pend <= 1'b0;
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CELLS: begin
        cells     <= prod[NW-1:0];
        set_count <= prod[NW-1:0];
        clr_idx   <= '0;
      end
      ST_CLEAR: begin
        clr_idx    <= clr_idx + CW'(1);
        res_status <= STATUS_RESTARTED;
      end
      ST_IDLE: begin
        wall <= s_tdata[WALL_W-1:0];
      end
      ST_PROP: begin
        if (set_count <= NW'(1)) begin
          res_status <= STATUS_COMPLETE;
        end else if (out_range) begin
          res_status <= STATUS_RANGE;
        end
      end
      ST_CHECK: begin
        res_status <= STATUS_BORDER;
        cur        <= cell_a;
      end
      ST_FIND_A: begin
        if (rdata == cur) begin
          ra  <= cur;
          cur <= b_cell;
        end else begin
          cur <= rdata;
        end
      end
      ST_FIND_B: begin
        if (rdata == cur) begin
          rb <= cur;
        end else begin
          cur <= rdata;
        end
      end
      ST_LINK: begin
        if (ra != rb) begin
          set_count  <= set_count - NW'(1);
          res_status <= STATUS_REMOVED;
        end else begin
          res_status <= STATUS_CONNECTED;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= {6'b0, (set_count == NW'(1)), sc_wide[10:0], wall, res_status};
        end
      end
      default: begin
      end
    endcase
  end

  // set count stays between one and the grid size
  a_set_count_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (set_count != '0) && (set_count <= cells))
    else $error("set count outside grid bounds");

  // root searches walk only cells of the grid
  a_find_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIND_A || state == ST_FIND_B) |-> (NW'(cur) < cells))
    else $error("root search left the grid");

  // a merge drops exactly one set
  a_merge_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINK && ra != rb && !cfg_we)
      |=> (set_count == $past(set_count) - NW'(1)))
    else $error("merge did not decrement set count");

  // a complete answer always reports a finished maze
  a_complete_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] == STATUS_COMPLETE) |-> m_tdata[25])
    else $error("complete status without maze done");

endmodule

// ===== tb/sv/kruskal_maze_wall_remover_tb.sv =====
// ----------------------------------------------------------------------------
// kruskal_maze_wall_remover_tb
// Self-checking bench for the maze wall remover. A queue of requests feeds a
// clocked stream driver, and every accepted request is run through a
// union-find model of the maze kept in the bench, which queues the result it
// should give. A clocked monitor compares each returned result field by field
// with the oldest queued one. Grid sizes are changed between phases, zero and
// oversized values among them. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module kruskal_maze_wall_remover_tb
  import kmwr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS_CAP = DEF_MAX_CELLS;

  typedef struct {
    logic              mode;
    logic [WALL_W-1:0] wall;
  } wall_req_t;

  typedef struct {
    kmwr_status_t      status;
    logic [WALL_W-1:0] wall;
    logic [10:0]       sets;
    logic              done;
  } maze_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;

  wall_req_t    req_queue[$];
  maze_result_t awaited[$];

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  bit          hold_sender = 1'b0;
  int unsigned errors = 0;

  // bench copy of the maze state
  logic [CFG_W-1:0] grid_cols = COLUMNS_RESET;
  logic [CFG_W-1:0] grid_rows = ROWS_RESET;
  logic [9:0]       cell_parent[CELLS_CAP];
  int unsigned      sets_now;

  kruskal_maze_wall_remover dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned used_cols();
    int unsigned c;
    c = grid_cols;
    if (c == 0) c = 1;
    if (c > CELLS_CAP) c = CELLS_CAP;
    return c;
  endfunction

  function automatic int unsigned used_rows();
    int unsigned r, lim;
    r   = grid_rows;
    lim = CELLS_CAP / used_cols();
    if (r == 0) r = 1;
    if (r > lim) r = lim;
    return r;
  endfunction

  function automatic void clear_maze();
    for (int i = 0; i < CELLS_CAP; i++) cell_parent[i] = i[9:0];
    sets_now = used_cols() * used_rows();
  endfunction

  function automatic logic [9:0] root_of(logic [9:0] c);
    logic [9:0] p;
    for (int s = 0; s < CELLS_CAP; s++) begin
      p = cell_parent[c];
      if (p == c) break;
      c = p;
    end
    return c;
  endfunction

  // work out the result of one accepted request and queue it
  function automatic void resolve_wall_request(logic mode, logic [WALL_W-1:0] wall);
    maze_result_t r;
    int unsigned  cols, rows, cells, a, b;
    logic [9:0]   ra, rb;
    bit           border;
    cols  = used_cols();
    rows  = used_rows();
    cells = cols * rows;
    if (mode == MODE_RESTART) begin
      clear_maze();
      r.status = STATUS_RESTARTED;
    end else if (sets_now <= 1) begin
      r.status = STATUS_COMPLETE;
    end else begin
      a = wall >> 1;
      if (a >= cells) begin
        r.status = STATUS_RANGE;
      end else begin
        if (wall[0] == 1'b0) begin
          border = ((a + 1) % cols) == 0;
          b      = a + 1;
        end else begin
          border = a >= cols * (rows - 1);
          b      = a + cols;
        end
        if (border) begin
          r.status = STATUS_BORDER;
        end else begin
          ra = root_of(a[9:0]);
          rb = root_of(b[9:0]);
          if (ra == rb) begin
            r.status = STATUS_CONNECTED;
          end else begin
            cell_parent[ra] = rb;
            sets_now--;
            r.status = STATUS_REMOVED;
          end
        end
      end
    end
    r.wall = wall;
    r.sets = sets_now[10:0];
    r.done = (sets_now == 1);
    awaited = {awaited, r};
  endfunction

  // driver: hold a request until accepted, then take the next one
  always @(posedge clk) begin
    logic      nxt_valid;
    wall_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        resolve_wall_request(s_tuser[0], s_tdata[WALL_W-1:0]);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && !hold_sender && req_queue.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        nxt = req_queue.pop_front();
        s_tdata   <= {5'd0, nxt.wall};
        s_tuser   <= nxt.mode;
        nxt_valid = 1'b1;
      end
      s_tvalid <= nxt_valid;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic flag_mismatch(string what, int unsigned exp_v, int unsigned act_v);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  // monitor
  always @(posedge clk) begin
    maze_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited.size() == 0) begin
        flag_mismatch("unrequested result, wall", 0, m_tdata[13:3]);
      end else begin
        e = awaited.pop_front();
        if (m_tdata[2:0] != e.status) flag_mismatch("status", e.status, m_tdata[2:0]);
        if (m_tdata[13:3] != e.wall) flag_mismatch("wall_echo", e.wall, m_tdata[13:3]);
        if (m_tdata[24:14] != e.sets) flag_mismatch("sets_left", e.sets, m_tdata[24:14]);
        if (m_tdata[25] != e.done) flag_mismatch("maze_done", e.done, m_tdata[25]);
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (rst || req_queue.size() != 0 || s_tvalid || awaited.size() != 0 || !s_tready)
      @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [10:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_COLUMNS) grid_cols = val;
    else grid_rows = val;
    clear_maze();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void push_req(logic mode, logic [WALL_W-1:0] wall);
    wall_req_t q;
    q.mode = mode;
    q.wall = wall;
    req_queue = {req_queue, q};
  endfunction

  // mostly walls inside the grid, a few restarts, some arbitrary indexes
  function automatic void push_random(int n);
    int unsigned cells, pick;
    cells = used_cols() * used_rows();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 4)
        push_req(MODE_RESTART, 11'($urandom_range(2047)));
      else if (pick < 14)
        push_req(MODE_PROPOSE, 11'($urandom_range(2047)));
      else
        push_req(MODE_PROPOSE,
                 {10'($urandom_range(cells - 1)), 1'($urandom_range(1))});
    end
  endfunction

  task automatic set_grid(logic [10:0] cols, logic [10:0] rows);
    write_register(REG_COLUMNS, cols);
    write_register(REG_ROWS, rows);
    wait_idle();
  endtask

  task automatic set_pace(int unsigned idle, int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  initial begin
    clear_maze();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // default 32 by 32 grid: corner walls and a restart
    push_req(MODE_PROPOSE, 11'd0);
    push_req(MODE_PROPOSE, 11'd2047);
    push_req(MODE_PROPOSE, 11'd2046);
    push_req(MODE_PROPOSE, 11'd62);
    push_req(MODE_RESTART, 11'd0);

    // 2 by 2 grid walked to completion
    set_grid(11'd2, 11'd2);
    push_req(MODE_PROPOSE, 11'd2047);
    push_req(MODE_PROPOSE, 11'd0);
    push_req(MODE_PROPOSE, 11'd0);
    push_req(MODE_PROPOSE, 11'd2);
    push_req(MODE_PROPOSE, 11'd3);
    push_req(MODE_PROPOSE, 11'd7);
    push_req(MODE_PROPOSE, 11'd6);
    push_req(MODE_PROPOSE, 11'd8);
    push_req(MODE_PROPOSE, 11'd1);
    push_req(MODE_PROPOSE, 11'd5);
    push_req(MODE_RESTART, 11'd2047);
    push_req(MODE_PROPOSE, 11'd4);
    push_req(MODE_RESTART, 11'd0);

    set_grid(11'd4, 11'd4);
    push_random(120);

    // oversized: clamps to one row of full capacity
    set_grid(11'd2047, 11'd2047);
    set_pace(50, 0);
    push_random(100);

    // zero geometry: a single cell, always complete
    set_grid(11'd0, 11'd0);
    set_pace(0, 50);
    push_random(20);

    set_grid(11'd1, 11'd1024);
    set_pace(36, 36);
    push_random(100);

    // rows clamp to capacity over columns; sender waits for a full drain once
    set_grid(11'd3, 11'd2047);
    set_pace(50, 0);
    push_random(100);
    @(negedge clk);
    while (req_queue.size() > 50) @(negedge clk);
    hold_sender = 1'b1;
    while (s_tvalid || awaited.size() != 0) @(negedge clk);
    hold_sender = 1'b0;

    set_grid(11'($urandom_range(1, 12)), 11'($urandom_range(1, 12)));
    set_pace(0, 50);
    push_random(120);

    set_grid(11'd7, 11'd5);
    set_pace(36, 36);
    push_random(120);

    set_grid(11'd1024, 11'd0);
    set_pace(0, 0);
    push_random(60);

    set_grid(11'($urandom_range(2047)), 11'($urandom_range(2047)));
    set_pace(36, 36);
    push_random(100);

    wait_idle();
    repeat (64) @(posedge clk);
    if (errors == 0 && awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== kruskal_maze_wall_remover.f =====
rtl/kmwr_pkg.sv
rtl/kmwr_div.sv
rtl/kruskal_maze_wall_remover.sv
tb/sv/kruskal_maze_wall_remover_tb.sv
